[sv/stp_pkg.sv]
package stp_pkg;

  // Request codes carried on req_type.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Direction codes carried on turn_direction.
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_ACW = 1'b1;

  // Fixed arithmetic constants of the drive.
  localparam int unsigned US_PER_MINUTE = 60000000;
  localparam int unsigned UNITS_PER_SEQ = 45;
  localparam int unsigned HALF_STEPS    = 8;

  // Field widths.
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned RPM_W    = 8;
  localparam int unsigned STEPS_W  = 14;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned COIL_W   = 4;

  // Phase index at the start of a move, per direction.
  localparam logic [2:0] PHASE_FIRST_CW  = 3'd7;
  localparam logic [2:0] PHASE_FIRST_ACW = 3'd0;

  // Standard 8-phase half-step table, bit 0 is the first coil.
  function automatic logic [COIL_W-1:0] coil_for(input logic [2:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

[sv/stepper_half_step_mover.sv]
// Tick, ignored start or start short of one sequence: accepted, executed in the next cycle,
// result then registered in S_OUT once the output register is free.
// A start that moves goes on from S_EXEC to S_DIV_PER, where the one-bit-per-cycle restoring
// divider works out the step period from speed_rpm, and then to S_OUT.
// One item at a time; a following item may be taken while a result waits, then holds in S_OUT.
// Synchronous active-high reset: coils off, no move, speed_rpm = 10, output empty.
module stepper_half_step_mover #(
  parameter int unsigned STEPS_PER_REV = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [stp_pkg::ANGLE_W-1:0] move_angle,
  input  logic                        turn_direction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stp_pkg::COIL_W-1:0]  coil_pattern,
  output logic                        busy_res,
  output logic                        move_done,
  input  logic                        cfg_we,
  input  logic [stp_pkg::RPM_W-1:0]   cfg_data
);
  import stp_pkg::*;

  // Divider sizing follows from the motor resolution.
  localparam int unsigned BASE   = US_PER_MINUTE / STEPS_PER_REV;
  localparam int unsigned BASE_W = $clog2(BASE + 1);
  localparam int unsigned DIV_W  = (BASE_W > PERIOD_W) ? BASE_W : PERIOD_W;
  localparam int unsigned CNT_W  = $clog2(DIV_W);
  localparam logic [DIV_W-1:0]    BASE_VAL = DIV_W'(BASE);
  localparam logic [DIV_W-1:0]    PER_MAX  = DIV_W'(17'h0FFFF);
  localparam logic [CNT_W-1:0]    CNT_LAST = CNT_W'(DIV_W - 1);
  localparam int unsigned         SHIFT_W  = $clog2(HALF_STEPS);

  // Reciprocal of the sequence angle; exact for every 16-bit angle.
  localparam int unsigned SEQ_SHIFT = 21;
  localparam int unsigned SEQ_RECIP = ((1 << SEQ_SHIFT) + UNITS_PER_SEQ - 1) / UNITS_PER_SEQ;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV_PER,
    S_OUT
  } state_t;

  state_t                state;
  logic                  req_l;
  logic [ANGLE_W-1:0]    angle_l;
  logic                  dir_l;
  logic [RPM_W-1:0]      speed_rpm;
  logic [STEPS_W-1:0]    steps_left;
  logic [2:0]            phase_index;
  logic [PERIOD_W-1:0]   tick_count;
  logic [PERIOD_W-1:0]   step_period;
  logic                  moving_dir;
  logic                  active;
  logic [COIL_W-1:0]     coils_now;
  logic                  done;

  // Divider registers.
  logic [DIV_W-1:0]      div_quo;
  logic [RPM_W-1:0]      div_rem;
  logic [RPM_W-1:0]      div_dvs;
  logic [CNT_W-1:0]      div_cnt;

  logic [RPM_W:0]        div_shift;
  logic [RPM_W+1:0]      div_trial;
  logic                  div_bit;
  logic [RPM_W-1:0]      div_rem_next;
  logic [DIV_W-1:0]      div_quo_next;

  logic [PERIOD_W-1:0]   tick_next;
  logic                  tick_end;
  logic [STEPS_W-1:0]    steps_dec;
  logic [2:0]            phase_next;
  logic [2*ANGLE_W-1:0]  seq_prod;
  logic [2*ANGLE_W-SEQ_SHIFT-1:0] seq_quo;
  logic [STEPS_W-1:0]    steps_from_q;

  assign in_stall = (state != S_IDLE);

  // One restoring division step: shift in the next dividend bit and try the subtract.
  always_comb begin
    div_shift    = {div_rem, div_quo[DIV_W-1]};
    div_trial    = {1'b0, div_shift} - {2'b00, div_dvs};
    div_bit      = ~div_trial[RPM_W+1];
    div_rem_next = div_bit ? div_trial[RPM_W-1:0] : div_shift[RPM_W-1:0];
    div_quo_next = {div_quo[DIV_W-2:0], div_bit};
  end

  // Tick arithmetic, and the half-step count from the angle by reciprocal multiplication.
  always_comb begin
    tick_next    = tick_count + PERIOD_W'(1);
    tick_end     = (req_l == REQ_TICK) && active && (tick_next >= step_period);
    steps_dec    = steps_left - STEPS_W'(1);
    phase_next   = (moving_dir == DIR_ACW) ? (phase_index + 3'd1) : (phase_index - 3'd1);
    seq_prod     = (2*ANGLE_W)'(angle_l) * (2*ANGLE_W)'(SEQ_RECIP);
    seq_quo      = seq_prod[2*ANGLE_W-1:SEQ_SHIFT];
    steps_from_q = STEPS_W'(seq_quo) << SHIFT_W;
  end

  // Sequencer, move state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      speed_rpm   <= RPM_W'(10);
      steps_left  <= '0;
      phase_index <= '0;
      tick_count  <= '0;
      step_period <= '0;
      moving_dir  <= DIR_CW;
      active      <= 1'b0;
      coils_now   <= '0;
      done        <= 1'b0;
      out_valid   <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        speed_rpm <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        // Take one item in.
        S_IDLE: begin
          if (in_valid) begin
            req_l   <= req_type;
            angle_l <= move_angle;
            dir_l   <= turn_direction;
            state   <= S_EXEC;
          end
        end

        // Ticks, ignored starts and short angles settle here; a real move goes to the divider.
        S_EXEC: begin
          if ((req_l == REQ_START) && !active) begin
            if (seq_quo == '0) begin
              done  <= 1'b1;
              state <= S_OUT;
            end else begin
              done       <= 1'b0;
              steps_left <= steps_from_q;
              div_quo    <= BASE_VAL;
              div_rem    <= '0;
              div_dvs    <= speed_rpm;
              div_cnt    <= CNT_LAST;
              state      <= S_DIV_PER;
            end
          end else begin
            done  <= tick_end && (steps_dec == '0);
            state <= S_OUT;
            if (tick_end) begin
              steps_left <= steps_dec;
              if (steps_dec == '0) begin
                active <= 1'b0;
              end else begin
                phase_index <= phase_next;
                coils_now   <= coil_for(phase_next);
                tick_count  <= '0;
              end
            end else if ((req_l == REQ_TICK) && active) begin
              tick_count <= tick_next;
            end
          end
        end

        // Step period in ticks; a zero speed gives all ones, which saturates.
        S_DIV_PER: begin
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == '0) begin
            step_period <= (div_quo_next > PER_MAX) ? PERIOD_W'(17'h0FFFF)
                                                    : div_quo_next[PERIOD_W-1:0];
            moving_dir  <= dir_l;
            phase_index <= (dir_l == DIR_ACW) ? PHASE_FIRST_ACW : PHASE_FIRST_CW;
            coils_now   <= coil_for((dir_l == DIR_ACW) ? PHASE_FIRST_ACW : PHASE_FIRST_CW);
            tick_count  <= '0;
            active      <= 1'b1;
            state       <= S_OUT;
          end
        end

        // Load the output register once it is free.
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            coil_pattern <= coils_now;
            busy_res     <= active;
            move_done    <= done;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A move in progress always has a half step left to finish.
  a_active_steps: assert property (@(posedge clk) disable iff (rst)
    active |-> (steps_left != '0))
    else $error("active move with no steps left");

  // A move in progress always drives at least one coil.
  a_active_coils: assert property (@(posedge clk) disable iff (rst)
    active |-> (coils_now != '0))
    else $error("active move with all coils off");

  // A finished move is never reported as busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && move_done) |-> !busy_res)
    else $error("move_done reported while busy");

  // An accepted transfer always starts work.
  a_accept_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted item not taken into execution");

  // The divider finishes with its count exhausted.
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV_PER) && (div_cnt == '0)) |=> (state == S_OUT))
    else $error("period division did not complete");

endmodule
